// ----- src/mmgt_pkg.sv -----
// Shared constants, types and state codes for the min/max gap tracker.
package mmgt_pkg;

   localparam int STORE_DEPTH = 64;
   localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNT_W = $clog2(STORE_DEPTH + 1);
   localparam int CAP_W = 7;
   localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int VAL_W = 32;
   localparam int GAP_W = 33;
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   localparam logic STATUS_STORED = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // Sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_WALK   = 4'b0010,
      ST_COMMIT = 4'b0100,
      ST_FINISH = 4'b1000
   } seq_state_type;

   // Store port controls from the sequencer
   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
   } store_ctl_type;

endpackage

// ----- src/mmgt_if.sv -----
// Valid/ready channel interfaces for the request and response sides.
interface mmgt_req_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface mmgt_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic        span_valid;
   logic [31:0] shortest_span;
   logic [31:0] longest_span;

   modport source (output valid, output status, output span_valid,
                   output shortest_span, output longest_span, input ready);
   modport sink (input valid, input status, input span_valid,
                 input shortest_span, input longest_span, output ready);
endinterface

// ----- src/mmgt_store.sv -----
// Number store: one write port, one registered read port.
module mmgt_store
   import mmgt_pkg::*;
(
   input  logic                    clock,
   input  store_ctl_type           ctl,
   input  logic signed [VAL_W-1:0] wr_data,
   output logic signed [VAL_W-1:0] rd_data
);

   logic signed [VAL_W-1:0] mem [STORE_DEPTH];
   logic signed [VAL_W-1:0] rd_data_ff;

   // Write the new number
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= wr_data;
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/mmgt_gap_unit.sv -----
// Shared absolute-difference and compare unit that keeps the least gap.
module mmgt_gap_unit
   import mmgt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmp_en,
   input  logic signed [VAL_W-1:0] new_value,
   input  logic signed [VAL_W-1:0] stored_value,
   output logic [GAP_W-1:0]        least_gap
);

   logic [GAP_W-1:0] gap_ff;
   logic [GAP_W-1:0] gap_in;
   logic [GAP_W-1:0] diff;
   logic [GAP_W-1:0] magnitude;

   // Form |new - stored| from a sign-extended difference
   always_comb begin
      diff = {new_value[VAL_W-1], new_value} - {stored_value[VAL_W-1], stored_value};
      magnitude = diff[GAP_W-1] ? (~diff + GAP_W'(1)) : diff;
      gap_in = gap_ff;
      if (cmp_en && (magnitude < gap_ff)) begin
         gap_in = magnitude;
      end
   end

   // Hold the running least gap
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= '1;
      end else begin
         gap_ff <= gap_in;
      end
   end

   assign least_gap = gap_ff;

endmodule

// ----- src/min_max_gap_tracker.sv -----
// Top level: sequencer, extremes, capacity register and response register.
// A stored number walks every stored entry in ST_WALK (skipped for the first number), is
// written in ST_COMMIT and reported from ST_FINISH, which a response stall holds; a rejected
// number goes straight to ST_FINISH. No new number is taken until ST_IDLE is back. The walk
// reads each stored entry through the single read port into the shared gap unit.
// Reset (synchronous, active high): count 0, capacity 64, least gap all ones; RAM not cleared.
module min_max_gap_tracker
   import mmgt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   mmgt_req_if.sink         req_bus,
   mmgt_rsp_if.source       rsp_bus,
   input  logic             csr_we,
   input  logic [CAP_W-1:0] csr_wdata
);

   seq_state_type           state_ff, state_in;
   logic [CAP_W-1:0]        capacity_ff;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        rd_idx_ff, rd_idx_in;
   logic signed [VAL_W-1:0] value_ff, value_in;
   logic signed [VAL_W-1:0] least_ff, least_in;
   logic signed [VAL_W-1:0] greatest_ff, greatest_in;
   logic                    status_ff, status_in;
   logic                    cmp_en_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_status_ff, rsp_span_valid_ff;
   logic [31:0]             rsp_shortest_ff, rsp_longest_ff;
   logic                    req_xfer, rsp_free, room, last_read, load_rsp;
   logic [VAL_W:0]          span_diff;
   logic [GAP_W-1:0]        least_gap;
   logic signed [VAL_W-1:0] rd_data;
   store_ctl_type           store_ctl;

   mmgt_store u_store (
      .clock   (clock),
      .ctl     (store_ctl),
      .wr_data (value_ff),
      .rd_data (rd_data)
   );

   mmgt_gap_unit u_gap (
      .clock        (clock),
      .reset        (reset),
      .cmp_en       (cmp_en_ff),
      .new_value    (value_ff),
      .stored_value (rd_data),
      .least_gap    (least_gap)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_xfer = req_bus.valid && req_bus.ready;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign room = (LIM_W'(count_ff) < LIM_W'(capacity_ff)) &&
                 (count_ff < CNT_W'(STORE_DEPTH));
   assign last_read = (CNT_W'(rd_idx_ff) == CNT_W'(count_ff - CNT_W'(1)));
   assign load_rsp = (state_ff == ST_FINISH) && rsp_free;
   assign span_diff = {greatest_ff[VAL_W-1], greatest_ff} - {least_ff[VAL_W-1], least_ff};

   // Drive the store ports
   always_comb begin
      store_ctl.rd_en = (state_ff == ST_WALK);
      store_ctl.rd_addr = rd_idx_ff;
      store_ctl.wr_en = (state_ff == ST_COMMIT);
      store_ctl.wr_addr = count_ff[IDX_W-1:0];
   end

   // Sequence one number: walk the store (when not empty), commit, then deliver; a rejected number is only delivered
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rd_idx_in = rd_idx_ff;
      value_in = value_ff;
      least_in = least_ff;
      greatest_in = greatest_ff;
      status_in = status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               value_in = req_bus.value;
               rd_idx_in = '0;
               if (!room) begin
                  status_in = STATUS_FULL;
                  state_in = ST_FINISH;
               end else begin
                  status_in = STATUS_STORED;
                  state_in = (count_ff == '0) ? ST_COMMIT : ST_WALK;
               end
            end
         end
         ST_WALK: begin
            rd_idx_in = rd_idx_ff + IDX_W'(1);
            if (last_read) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (count_ff == '0) begin
               least_in = value_ff;
               greatest_in = value_ff;
            end else begin
               if (value_ff < least_ff) begin
                  least_in = value_ff;
               end
               if (value_ff > greatest_ff) begin
                  greatest_in = value_ff;
               end
            end
            count_in = count_ff + CNT_W'(1);
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         least_ff <= '0;
         greatest_ff <= '0;
         cmp_en_ff <= 1'b0;
         capacity_ff <= CAP_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         least_ff <= least_in;
         greatest_ff <= greatest_in;
         cmp_en_ff <= (state_ff == ST_WALK);
         if (csr_we) begin
            capacity_ff <= csr_wdata;
         end
      end
   end

   // Hold the working payload
   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      value_ff <= value_in;
      status_ff <= status_in;
   end

   // Hold the result until its transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff <= status_ff;
         if (count_ff >= CNT_W'(2)) begin
            rsp_span_valid_ff <= 1'b1;
            rsp_shortest_ff <= least_gap[31:0];
            rsp_longest_ff <= span_diff[31:0];
         end else begin
            rsp_span_valid_ff <= 1'b0;
            rsp_shortest_ff <= '0;
            rsp_longest_ff <= '0;
         end
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.status = rsp_status_ff;
   assign rsp_bus.span_valid = rsp_span_valid_ff;
   assign rsp_bus.shortest_span = rsp_shortest_ff;
   assign rsp_bus.longest_span = rsp_longest_ff;

endmodule

// ----- src/mmgt_checker.sv -----
// Port-level assertions for the min/max gap tracker, bound to the top level.
module mmgt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_status,
   input logic        rsp_span_valid,
   input logic [31:0] rsp_shortest_span,
   input logic [31:0] rsp_longest_span
);

   // Busy after every accepted request
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous one still in work");

   // Stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) &&
         $stable(rsp_span_valid) && $stable(rsp_shortest_span) &&
         $stable(rsp_longest_span)))
      else $error("stalled result changed");

   // Spans read zero with fewer than two stored
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_span_valid) |->
         (rsp_shortest_span == 32'd0 && rsp_longest_span == 32'd0))
      else $error("nonzero span without a valid pair");

   // Shortest span never exceeds longest span
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_span_valid) |-> (rsp_shortest_span <= rsp_longest_span))
      else $error("shortest span above longest span");

endmodule

bind min_max_gap_tracker mmgt_checker u_mmgt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_status        (rsp_bus.status),
   .rsp_span_valid    (rsp_bus.span_valid),
   .rsp_shortest_span (rsp_bus.shortest_span),
   .rsp_longest_span  (rsp_bus.longest_span)
);

// ----- tb/min_max_gap_tracker_tb.sv -----
// Self-checking testbench for the min/max gap tracker: directed and random numbers.
`timescale 1ns / 1ps

module min_max_gap_tracker_tb;
   import mmgt_pkg::*;

   localparam int QUIET_LIMIT = 4000;

   // One response as the block should report it
   typedef struct {
      logic        status;
      logic        span_valid;
      logic [31:0] shortest_span;
      logic [31:0] longest_span;
   } span_report_type;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [CAP_W-1:0] csr_wdata;

   mmgt_req_if req_bus ();
   mmgt_rsp_if rsp_bus ();

   min_max_gap_tracker i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Shadow of the tracked set and the capacity register
   logic signed [31:0] kept_values [STORE_DEPTH];
   int                 kept_count = 0;
   logic signed [31:0] kept_min = '0;
   logic signed [31:0] kept_max = '0;
   logic [GAP_W-1:0]   kept_gap = '1;
   logic [CAP_W-1:0]   cap_shadow = CAP_RESET;

   span_report_type pending_reports[$];
   int              fail_count = 0;
   int              quiet_cycles = 0;
   int              send_idle_pct = 0;
   int              rsp_stall_pct = 0;
   int              rsp_hold_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Absolute difference of two signed numbers, 33 bits so it never wraps
   function automatic logic [GAP_W-1:0] span_of(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      logic signed [GAP_W-1:0] diff;
      diff = {a[31], a} - {b[31], b};
      return diff[GAP_W-1] ? -diff : diff;
   endfunction

   // Add one number to the shadow set and return the report it should cause
   function automatic span_report_type absorb_number(input logic signed [31:0] v);
      span_report_type  rep;
      int               room;
      logic [GAP_W-1:0] d;
      room = (cap_shadow < STORE_DEPTH) ? int'(cap_shadow) : STORE_DEPTH;
      if (kept_count < room) begin
         for (int i = 0; i < kept_count; i++) begin
            d = span_of(v, kept_values[i]);
            if (d < kept_gap) kept_gap = d;
         end
         if (kept_count == 0) begin
            kept_min = v;
            kept_max = v;
         end else begin
            if (v < kept_min) kept_min = v;
            if (v > kept_max) kept_max = v;
         end
         kept_values[kept_count] = v;
         kept_count++;
         rep.status = STATUS_STORED;
      end else begin
         rep.status = STATUS_FULL;
      end
      if (kept_count >= 2) begin
         d = span_of(kept_max, kept_min);
         rep.span_valid = 1'b1;
         rep.shortest_span = kept_gap[31:0];
         rep.longest_span = d[31:0];
      end else begin
         rep.span_valid = 1'b0;
         rep.shortest_span = '0;
         rep.longest_span = '0;
      end
      return rep;
   endfunction

   // Compare one response with the oldest pending report
   function automatic void check_report();
      span_report_type want;
      if (pending_reports.size() == 0) begin
         $error("response with no pending report: status %0b span_valid %0b",
                rsp_bus.status, rsp_bus.span_valid);
         fail_count++;
         return;
      end
      want = pending_reports.pop_front();
      if (rsp_bus.status !== want.status) begin
         $error("status: expected %0b, got %0b", want.status, rsp_bus.status);
         fail_count++;
      end
      if (rsp_bus.span_valid !== want.span_valid) begin
         $error("span_valid: expected %0b, got %0b", want.span_valid, rsp_bus.span_valid);
         fail_count++;
      end
      if (rsp_bus.shortest_span !== want.shortest_span) begin
         $error("shortest_span: expected %0d, got %0d",
                want.shortest_span, rsp_bus.shortest_span);
         fail_count++;
      end
      if (rsp_bus.longest_span !== want.longest_span) begin
         $error("longest_span: expected %0d, got %0d",
                want.longest_span, rsp_bus.longest_span);
         fail_count++;
      end
   endfunction

   // Track register writes, predict on each request transfer, check each response
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) cap_shadow = csr_wdata;
         if (rsp_bus.valid && rsp_bus.ready) check_report();
         if (req_bus.valid && req_bus.ready)
            pending_reports.insert(pending_reports.size(), absorb_number(req_bus.value));
         if (csr_we || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Drive ready: hold off while a stall stretch is pending, else stall at random
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready = 1'b0;
      end else if (rsp_hold_cycles > 0) begin
         rsp_bus.ready = 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp_bus.ready = ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Offer one number and hold it until the transfer
   task automatic send_number(input logic signed [31:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.value = v;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid and wait until every pending report has come back
   task automatic wait_drained();
      req_bus.valid = 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      csr_wdata = cap;
      csr_we = 1'b1;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_idling(input int send_pct, input int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // Mix wide random numbers, near neighbors of stored ones and a tight cluster
   function automatic logic signed [31:0] pick_fill_value();
      logic signed [31:0] near;
      int unsigned        offset;
      case ((kept_count == 0) ? 0 : $urandom_range(2))
         0: begin
            return $urandom;
         end
         1: begin
            near = kept_values[$urandom_range(kept_count - 1)];
            offset = $urandom_range(65535, 1);
            return $urandom_range(1) ? near + offset : near - offset;
         end
         default: begin
            return $signed($urandom_range(2000)) - 1000;
         end
      endcase
   endfunction

   // Capacity zero rejects everything, including the field extremes
   task automatic test_zero_capacity();
      write_capacity(7'd0);
      send_number(32'sh8000_0000);
      send_number(32'sh7FFF_FFFF);
      send_number(32'sd0);
      send_number(-32'sd1);
      wait_drained();
   endtask

   // One stored number gives no span yet
   task automatic test_single_entry();
      write_capacity(7'd1);
      send_number(32'sd1000);
      send_number(32'sd5);
      wait_drained();
   endtask

   // Second number makes both spans valid
   task automatic test_first_span();
      write_capacity(7'd2);
      send_number(-32'sd1000);
      send_number(32'sd7);
      wait_drained();
   endtask

   // Capacity above the store depth saturates; extend max and min, then an interior number
   task automatic test_saturated_capacity();
      write_capacity(7'd127);
      send_number(32'sd400_000_000);
      send_number(-32'sd900_000_000);
      send_number(32'sd123_456_789);
      wait_drained();
   endtask

   // Capacity lowered below the count keeps the set and rejects new numbers
   task automatic test_lowered_capacity();
      write_capacity(7'd3);
      send_number(32'sd42);
      send_number(-32'sd42);
      wait_drained();
      write_capacity(7'(STORE_DEPTH));
   endtask

   // Fill most of the store with random numbers under every idling pattern
   task automatic test_random_fill();
      set_idling(0, 0);
      repeat (14) send_number(pick_fill_value());
      set_idling(62, 0);
      repeat (14) send_number(pick_fill_value());
      // stall the response side for a long stretch while requests keep coming
      set_idling(0, 62);
      rsp_hold_cycles = 400;
      repeat (14) send_number(pick_fill_value());
      set_idling(16, 16);
      repeat (6) send_number(pick_fill_value());
      wait_drained();
      repeat (7) send_number(pick_fill_value());
      wait_drained();
      set_idling(0, 0);
   endtask

   // Duplicate drives the shortest span to zero; field extremes give the widest span
   task automatic test_extreme_values();
      send_number(kept_values[0]);
      send_number(32'sh8000_0000);
      send_number(32'sh7FFF_FFFF);
      send_number(pick_fill_value());
      wait_drained();
      write_capacity(7'd127);
      send_number(32'sd99);
      wait_drained();
   endtask

   // Full store: every random number is rejected and the spans hold
   task automatic test_random_rejects();
      set_idling(0, 0);
      repeat (80) send_number($urandom);
      set_idling(62, 0);
      repeat (80) send_number($urandom);
      set_idling(0, 62);
      repeat (80) send_number($urandom);
      set_idling(16, 16);
      repeat (80) send_number($urandom);
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_zero_capacity();
      test_single_entry();
      test_first_span();
      test_saturated_capacity();
      test_lowered_capacity();
      test_random_fill();
      test_extreme_values();
      test_random_rejects();

      // let any stray response show up before the verdict
      repeat (80) @(negedge clock);
      if (fail_count == 0 && pending_reports.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
